// ----- rtl/core/cls_pkg.sv -----
// Shared types and constants for the cursor linked-list store.
// No dependencies; imported by every module of the block.
package cls_pkg;

  localparam int POS_W = 4;
  localparam int LEN_W = 4;
  localparam int VAL_W = 32;

  // Command codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_DELETE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  // One result word
  typedef struct packed {
    status_t            status;
    logic [LEN_W-1:0]   list_length;
  } result_t;

endpackage

// ----- rtl/core/cursor_linked_list_store.sv -----
// Cursor linked-list store (cls_pkg, cls_link_ram, cls_ctrl): insert or delete by position.
// A bad position goes straight to the result; an insert into a full store stops after the
// free-chain read; otherwise the cursor walks the list through the registered link store
// read port. One command at a time: the next word is taken the cycle after the result
// is registered; a stalled result holds the sequencer.
// Reset: a clearing pass over all link slots rebuilds the free chain; in_stall stays high.
module cursor_linked_list_store
  import cls_pkg::*;
#(
  parameter int NODE_SLOTS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_command,
  input  logic [POS_W-1:0]        in_position,
  input  logic signed [VAL_W-1:0] in_value,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [1:0]              out_status,
  output logic [LEN_W-1:0]        out_list_length
);

  localparam int AW = $clog2(NODE_SLOTS);

  logic                    link_we;
  logic [AW-1:0]           link_waddr, link_wdata, link_raddr, link_rdata;
  logic                    val_we;
  logic [AW-1:0]           val_addr;
  logic signed [VAL_W-1:0] val_wdata;
  result_t                 out_res;

  // Element values are only written; the list order lives in the links
  logic signed [VAL_W-1:0] node_values_r [NODE_SLOTS];

  always_ff @(posedge clk) begin
    if (val_we) begin
      node_values_r[val_addr] <= val_wdata;
    end
  end

  cls_link_ram #(
    .DEPTH (NODE_SLOTS)
  ) u_links (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (link_raddr),
    .rdata (link_rdata)
  );

  cls_ctrl #(
    .NODE_SLOTS (NODE_SLOTS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_command  (in_command),
    .in_position (in_position),
    .in_value    (in_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_res     (out_res),
    .link_we     (link_we),
    .link_waddr  (link_waddr),
    .link_wdata  (link_wdata),
    .link_raddr  (link_raddr),
    .link_rdata  (link_rdata),
    .val_we      (val_we),
    .val_addr    (val_addr),
    .val_wdata   (val_wdata)
  );

  assign out_status      = out_res.status;
  assign out_list_length = out_res.list_length;

endmodule

// ----- rtl/core/cls_link_ram.sv -----
// Link store: one write port, one read port with registered read data.
// Depends on cls_pkg.
module cls_link_ram
  import cls_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [$clog2(DEPTH)-1:0] wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [$clog2(DEPTH)-1:0] rdata
);

  logic [$clog2(DEPTH)-1:0] mem_r [DEPTH];
  logic [$clog2(DEPTH)-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/cls_ctrl.sv -----
// Command sequencer: clearing pass, cursor walk, splice steps, result register.
// Depends on cls_pkg; drives the link store ports and the value store write.
module cls_ctrl
  import cls_pkg::*;
#(
  parameter int NODE_SLOTS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_command,
  input  logic [POS_W-1:0]              in_position,
  input  logic signed [VAL_W-1:0]       in_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output result_t                       out_res,
  output logic                          link_we,
  output logic [$clog2(NODE_SLOTS)-1:0] link_waddr,
  output logic [$clog2(NODE_SLOTS)-1:0] link_wdata,
  output logic [$clog2(NODE_SLOTS)-1:0] link_raddr,
  input  logic [$clog2(NODE_SLOTS)-1:0] link_rdata,
  output logic                          val_we,
  output logic [$clog2(NODE_SLOTS)-1:0] val_addr,
  output logic signed [VAL_W-1:0]       val_wdata
);

  localparam int AW = $clog2(NODE_SLOTS);
  localparam int CW = $clog2(NODE_SLOTS - 1);
  localparam int CMP_W = ((CW > POS_W) ? CW : POS_W) + 1;
  localparam logic [AW-1:0] HEAD_SLOT = AW'(NODE_SLOTS - 1);
  localparam logic [AW-1:0] LAST_FREE = AW'(NODE_SLOTS - 2);
  localparam logic [AW-1:0] FREE_HEAD = '0;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_I_FREE, S_I_FRESH, S_I_UNLINK, S_WALK, S_WALK_GET,
    S_I_SPLICE, S_I_LINK, S_D_VICTIM, S_D_BYPASS, S_D_FREE, S_D_PUSH, S_DONE
  } state_t;

  state_t                   state_r, state_nxt;
  logic [AW-1:0]            k_r, k_nxt;
  logic [AW-1:0]            node_r, node_nxt;
  logic [POS_W-1:0]         step_r, step_nxt;
  logic [POS_W-1:0]         pos_r, pos_nxt;
  logic                     cmd_r, cmd_nxt;
  logic signed [VAL_W-1:0]  value_r, value_nxt;
  logic [CW-1:0]            cnt_r, cnt_nxt;
  status_t                  stat_r, stat_nxt;
  logic                     out_valid_r, out_valid_nxt;
  result_t                  out_res_r, out_res_nxt;
  logic [CMP_W-1:0]         pos_ext, cnt_ext;
  logic                     bad_pos;

  assign pos_ext = CMP_W'(in_position);
  assign cnt_ext = CMP_W'(cnt_r);

  // Range check at accept time
  always_comb begin
    if (in_command == CMD_INSERT) begin
      bad_pos = (pos_ext == '0) || (pos_ext > (cnt_ext + CMP_W'(1)));
    end else begin
      bad_pos = (pos_ext == '0) || (pos_ext > cnt_ext);
    end
  end

  // Next state and store controls
  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    node_nxt      = node_r;
    step_nxt      = step_r;
    pos_nxt       = pos_r;
    cmd_nxt       = cmd_r;
    value_nxt     = value_r;
    cnt_nxt       = cnt_r;
    stat_nxt      = stat_r;
    out_res_nxt   = out_res_r;
    out_valid_nxt = out_valid_r && out_stall;
    link_we       = 1'b0;
    link_waddr    = k_r;
    link_wdata    = '0;
    link_raddr    = k_r;
    val_we        = 1'b0;

    case (state_r)
      // Clearing pass: build free chain 0..N-2, empty list at head slot
      S_INIT: begin
        link_we    = 1'b1;
        link_waddr = k_r;
        link_wdata = (k_r < LAST_FREE) ? (k_r + AW'(1)) : '0;
        if (k_r == HEAD_SLOT) begin
          state_nxt = S_IDLE;
        end else begin
          k_nxt = k_r + AW'(1);
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = in_command;
          pos_nxt   = in_position;
          value_nxt = in_value;
          k_nxt     = HEAD_SLOT;
          step_nxt  = POS_W'(1);
          if (bad_pos) begin
            stat_nxt  = ST_BAD_POS;
            state_nxt = S_DONE;
          end else if (in_command == CMD_INSERT) begin
            state_nxt = S_I_FREE;
          end else begin
            state_nxt = S_WALK;
          end
        end
      end
      // Insert: pop the first free node
      S_I_FREE: begin
        link_raddr = FREE_HEAD;
        state_nxt  = S_I_FRESH;
      end
      S_I_FRESH: begin
        if (link_rdata == '0) begin
          stat_nxt  = ST_FULL;
          state_nxt = S_DONE;
        end else begin
          node_nxt   = link_rdata;
          link_raddr = link_rdata;
          state_nxt  = S_I_UNLINK;
        end
      end
      S_I_UNLINK: begin
        link_we    = 1'b1;
        link_waddr = FREE_HEAD;
        link_wdata = link_rdata;
        val_we     = 1'b1;
        state_nxt  = S_WALK;
      end
      // Cursor walk to the predecessor of the target element
      S_WALK: begin
        link_raddr = k_r;
        if (step_r < pos_r) begin
          state_nxt = S_WALK_GET;
        end else if (cmd_r == CMD_INSERT) begin
          state_nxt = S_I_SPLICE;
        end else begin
          state_nxt = S_D_VICTIM;
        end
      end
      S_WALK_GET: begin
        k_nxt     = link_rdata;
        step_nxt  = step_r + POS_W'(1);
        state_nxt = S_WALK;
      end
      // Insert: fresh -> link(k), then k -> fresh
      S_I_SPLICE: begin
        link_we    = 1'b1;
        link_waddr = node_r;
        link_wdata = link_rdata;
        state_nxt  = S_I_LINK;
      end
      S_I_LINK: begin
        link_we    = 1'b1;
        link_waddr = k_r;
        link_wdata = node_r;
        cnt_nxt    = cnt_r + CW'(1);
        stat_nxt   = ST_OK;
        state_nxt  = S_DONE;
      end
      // Delete: unlink victim and push it on the free chain
      S_D_VICTIM: begin
        stat_nxt = ST_OK;
        if (link_rdata == '0) begin
          state_nxt = S_DONE;
        end else begin
          node_nxt   = link_rdata;
          link_raddr = link_rdata;
          state_nxt  = S_D_BYPASS;
        end
      end
      S_D_BYPASS: begin
        link_we    = 1'b1;
        link_waddr = k_r;
        link_wdata = link_rdata;
        link_raddr = FREE_HEAD;
        state_nxt  = S_D_FREE;
      end
      S_D_FREE: begin
        link_we    = 1'b1;
        link_waddr = node_r;
        link_wdata = link_rdata;
        state_nxt  = S_D_PUSH;
      end
      S_D_PUSH: begin
        link_we    = 1'b1;
        link_waddr = FREE_HEAD;
        link_wdata = node_r;
        cnt_nxt    = cnt_r - CW'(1);
        state_nxt  = S_DONE;
      end
      // Hand the result word to the output register
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt           = 1'b1;
          out_res_nxt.status      = stat_r;
          out_res_nxt.list_length = LEN_W'(cnt_r);
          state_nxt               = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      k_r         <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    node_r    <= node_nxt;
    step_r    <= step_nxt;
    pos_r     <= pos_nxt;
    cmd_r     <= cmd_nxt;
    value_r   <= value_nxt;
    stat_r    <= stat_nxt;
    out_res_r <= out_res_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;
  assign val_addr  = node_r;
  assign val_wdata = value_r;

  // Checks
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(cnt_r) <= CMP_W'(NODE_SLOTS - 2))
    else $error("element count above capacity");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != $past(cnt_r)) |->
      ((cnt_r == $past(cnt_r) + CW'(1)) || (cnt_r == $past(cnt_r) - CW'(1))))
    else $error("element count moved by more than one");

  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_DONE) |-> !link_we)
    else $error("link write outside a command");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result word without a finished command");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r != S_IDLE))
    else $error("accepted command did not start");

endmodule

// ----- tb/tb_top.sv -----
// Self-checking bench for cursor_linked_list_store: insert/delete words with
// random idling on both channels, checked against a built-in list predictor.
// Depends on cls_pkg and the cursor_linked_list_store RTL.
`timescale 1ns / 1ps

module tb_top;
  import cls_pkg::*;

  localparam int SLOTS      = 16;
  localparam int HEAD       = SLOTS - 1;
  localparam int MAX_ELEMS  = SLOTS - 2;
  localparam int RAND_WORDS = 1000;

  // Predicts the list store and keeps the results still owed by the block
  class list_store_sb;
    logic [POS_W-1:0]        link_tbl[SLOTS];
    logic signed [VAL_W-1:0] value_tbl[SLOTS];
    logic [LEN_W-1:0]        elem_count;
    result_t                 expected_results[$];
    int errors, n_insert, n_delete, n_ok, n_bad, n_full, peak_len;

    function new();
      for (int s = 0; s < SLOTS; s++) link_tbl[s] = '0;
      for (int s = 0; s + 2 < SLOTS; s++) link_tbl[s] = POS_W'(s + 1);
      elem_count = '0;
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    // Slot whose link points at element number pos
    function int pred_slot(int pos);
      int k;
      k = HEAD;
      for (int step = 1; step < pos; step++) k = link_tbl[k];
      return k;
    endfunction

    // Apply one accepted command word and queue its expected result
    function void note_command(logic cmd, logic [POS_W-1:0] pos,
                               logic signed [VAL_W-1:0] val);
      status_t st;
      result_t res;
      int      fresh, k, victim;
      st = ST_OK;
      if (cmd == CMD_INSERT) begin
        n_insert++;
        if (pos == 0 || int'(pos) > int'(elem_count) + 1) begin
          st = ST_BAD_POS;
        end else begin
          fresh = link_tbl[0];
          if (fresh == 0) begin
            st = ST_FULL;
          end else begin
            link_tbl[0] = link_tbl[fresh];
            value_tbl[fresh] = val;
            k = pred_slot(pos);
            link_tbl[fresh] = link_tbl[k];
            link_tbl[k] = POS_W'(fresh);
            elem_count++;
          end
        end
      end else begin
        n_delete++;
        if (pos == 0 || int'(pos) > int'(elem_count)) begin
          st = ST_BAD_POS;
        end else begin
          k = pred_slot(pos);
          victim = link_tbl[k];
          if (victim != 0) begin
            link_tbl[k] = link_tbl[victim];
            link_tbl[victim] = link_tbl[0];
            link_tbl[0] = POS_W'(victim);
            elem_count--;
          end
        end
      end
      case (st)
        ST_OK:      n_ok++;
        ST_BAD_POS: n_bad++;
        default:    n_full++;
      endcase
      if (elem_count > peak_len) peak_len = elem_count;
      res.status = st;
      res.list_length = elem_count;
      expected_results.push_back(res);
    endfunction

    // Compare one accepted result word with the oldest expectation
    task check_result(logic [1:0] got_status, logic [LEN_W-1:0] got_len);
      result_t exp;
      if (expected_results.size() == 0) begin
        report($sformatf("unexpected result status=%0d length=%0d",
                         got_status, got_len));
      end else begin
        exp = expected_results.pop_front();
        if (got_status !== exp.status)
          report($sformatf("status expected %0d got %0d", exp.status, got_status));
        if (got_len !== exp.list_length)
          report($sformatf("list_length expected %0d got %0d",
                           exp.list_length, got_len));
      end
    endtask
  endclass

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic                    in_command;
  logic [POS_W-1:0]        in_position;
  logic signed [VAL_W-1:0] in_value;
  logic                    out_valid;
  logic                    out_stall;
  logic [1:0]              out_status;
  logic [LEN_W-1:0]        out_list_length;

  list_store_sb sb = new();
  int           burst_left;

  cursor_linked_list_store #(.NODE_SLOTS(SLOTS)) uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_position     (in_position),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_list_length (out_list_length)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Result side: random stall, mostly short, a few long, some quiet stretches
  initial begin
    int r;
    out_stall = 1'b0;
    forever begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else if (r < 88) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else if (r < 94) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(10, 40)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(20, 60)) @(posedge clk);
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_status, out_list_length);
  end

  // Send one command word, note it on acceptance, then idle a random gap
  task send_word(logic cmd, logic [POS_W-1:0] pos, logic signed [VAL_W-1:0] val);
    int r, gap;
    in_valid    <= 1'b1;
    in_command  <= cmd;
    in_position <= pos;
    in_value    <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_command(cmd, pos, val);
    r = $urandom_range(0, 99);
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else if ($urandom_range(0, 63) == 0) begin
      burst_left = $urandom_range(10, 40);
      gap = 0;
    end else if (r < 60) begin
      gap = 0;
    end else if (r < 90) begin
      gap = $urandom_range(1, 3);
    end else begin
      gap = $urandom_range(8, 30);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Random word: mostly legal positions that sweep the list between empty and
  // full, with some noise on position and command
  task automatic send_random_word(ref bit filling);
    int                      len, r;
    logic                    cmd;
    logic [POS_W-1:0]        pos;
    logic signed [VAL_W-1:0] val;
    len = sb.elem_count;
    if (len == MAX_ELEMS && $urandom_range(0, 3) == 0) filling = 1'b0;
    if (len == 0 && $urandom_range(0, 2) == 0) filling = 1'b1;
    r = $urandom_range(0, 99);
    case ($urandom_range(0, 9))
      0:       val = 32'sh7fff_ffff;
      1:       val = 32'sh8000_0000;
      default: val = $urandom;
    endcase
    if (r < 8) begin
      cmd = $urandom_range(0, 1) ? CMD_DELETE : CMD_INSERT;
      pos = POS_W'($urandom_range(0, 15));
    end else begin
      cmd = ($urandom_range(0, 99) < 75) == filling ? CMD_INSERT : CMD_DELETE;
      if (cmd == CMD_INSERT)
        pos = POS_W'($urandom_range(1, len + 1));
      else
        pos = (len == 0) ? POS_W'($urandom_range(0, 15)) : POS_W'($urandom_range(1, len));
    end
    send_word(cmd, pos, val);
  endtask

  initial begin
    bit      filling;
    int      waited;
    result_t left;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_command  = CMD_INSERT;
    in_position = '0;
    in_value    = '0;
    burst_left  = 0;
    filling     = 1'b1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: bad positions on an empty list
    send_word(CMD_INSERT, 4'd0, 32'sd1);
    send_word(CMD_DELETE, 4'd1, 32'sd0);
    send_word(CMD_DELETE, 4'd0, -32'sd1);
    send_word(CMD_INSERT, 4'd2, 32'sd5);
    // head, front, tail and middle inserts with extreme values
    send_word(CMD_INSERT, 4'd1, 32'sh7fff_ffff);
    send_word(CMD_INSERT, 4'd1, 32'sh8000_0000);
    send_word(CMD_INSERT, 4'd3, 32'sd0);
    send_word(CMD_INSERT, 4'd2, -32'sd1);
    // fill to capacity by appending
    for (int i = 0; i < MAX_ELEMS - 4; i++)
      send_word(CMD_INSERT, sb.elem_count + 4'd1, i[0] ? 32'sh5555_5555 : 32'shaaaa_aaaa);
    // store full: legal position gives full, bad position is caught first
    send_word(CMD_INSERT, 4'd15, 32'sd7);
    send_word(CMD_INSERT, 4'd0, 32'sd7);
    send_word(CMD_INSERT, 4'd7, 32'sd7);
    // deletes: past the end, last, first, middle
    send_word(CMD_DELETE, 4'd15, 32'sd0);
    send_word(CMD_DELETE, 4'd14, 32'sd0);
    send_word(CMD_DELETE, 4'd1, 32'sd0);
    send_word(CMD_DELETE, 4'd6, 32'sd0);

    // Random part
    filling = 1'b0;
    for (int n = 0; n < RAND_WORDS; n++) send_random_word(filling);
    in_valid <= 1'b0;

    // Drain outstanding results, then allow for a slow straggler
    waited = 0;
    while (sb.expected_results.size() > 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (64) @(posedge clk);
    while (sb.expected_results.size() > 0) begin
      left = sb.expected_results.pop_front();
      sb.report($sformatf("missing result status=%0d length=%0d",
                          left.status, left.list_length));
    end

    $display("Ran %0d inserts and %0d deletes; results ok %0d, bad position %0d,",
             sb.n_insert, sb.n_delete, sb.n_ok, sb.n_bad);
    $display("store full %0d; longest list %0d; mismatches %0d",
             sb.n_full, sb.peak_len, sb.errors);
    if (sb.errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
